@@ hw/rtl/sas_pkg.sv @@
// Package for the symmetry axis search block.
// Holds the sequencer state type, register index codes and fixed field widths.
// No dependencies.
package sas_pkg;

	// Fixed field widths of the pixel, result and register ports.
	localparam int PIX_W   = 8;
	localparam int COST_W  = 21;
	localparam int AXIS_W  = 13;
	localparam int LEFT_W  = 12;
	localparam int BW_W    = 8;
	localparam int BH_W    = 7;
	localparam int STEP_W  = 12;
	localparam int CFG_W   = 12;
	localparam int CIDX_W  = 2;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	// Configuration register indexes.
	typedef enum logic [CIDX_W-1:0] {
		CFG_BOX_LEFT   = 2'd0,
		CFG_BOX_WIDTH  = 2'd1,
		CFG_BOX_HEIGHT = 2'd2,
		CFG_MAX_STEP   = 2'd3
	} cfg_idx_t;

	// Search sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

endpackage

@@ hw/rtl/symmetry_axis_search.sv @@
// Symmetry axis search: pixel store, search sequencer and difference-accumulate unit.
// A pixel request without last gives no result. A request with last starts a search of
// width * height * steps mirror terms, one per cycle through the two read ports of the
// pixel memory and one shared absolute difference accumulator, with done at its end;
// an empty box, no rows or no steps give done in the next cycle. busy blocks requests
// in a search; results cannot stall. arst_n clears all but memory and its read data.
module symmetry_axis_search
	import sas_pkg::*;
#(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	// Pixel requests
	input  logic              start,
	output logic              busy,
	input  logic [PIX_W-1:0]  pixel,
	input  logic              last,
	// Result
	output logic              done,
	output logic              found,
	output logic [AXIS_W-1:0] axis_x,
	output logic [COST_W-1:0] cost,
	// Configuration writes
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int XW    = CW + 1;

	// Configuration registers
	logic [LEFT_W-1:0] box_left_q;
	logic [BW_W-1:0]   box_width_q;
	logic [BH_W-1:0]   box_height_q;
	logic [STEP_W-1:0] max_step_q;

	// Search geometry latched at the start of a search
	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [CW-1:0] steps_q;

	// Issue counters
	state_t        state_q, state_d;
	logic [CW-1:0] c_q;
	logic [RW-1:0] r_q;
	logic [CW-1:0] s_q;
	logic [AW-1:0] row_base_q;
	logic [AW-1:0] load_idx_q;

	// Read stage
	logic [PIX_W-1:0] rd_a_s1, rd_b_s1;
	logic             term_s1, va_s1, vb_s1, col_end_s1, last_col_s1;
	logic [CW-1:0]    col_s1;

	// Accumulator and best column
	logic [COST_W-1:0] sum_q, best_q;
	logic [CW-1:0]     best_col_q;

	// Result registers
	logic              done_q, found_q;
	logic [AXIS_W-1:0] axis_q;
	logic [COST_W-1:0] cost_q;

	// Pixel memory
	logic [PIX_W-1:0] mem [DEPTH];

	logic              accept, accept_last;
	logic [WW-1:0]     w_new;
	logic [HW-1:0]     h_new;
	logic [CW-1:0]     steps_new;
	logic              s_wrap, r_wrap, c_wrap;
	logic              va, vb;
	logic [AW:0]       addr_a_x, addr_b_x;
	logic [AW-1:0]     addr_a, addr_b;
	logic [PIX_W-1:0]  pa, pb, diff;
	logic [COST_W:0]   acc_x;
	logic [COST_W-1:0] acc_sat;
	logic              better;
	logic [COST_W-1:0] best_new;
	logic [CW-1:0]     best_col_new;

	assign cfg_ready   = !busy;
	assign accept      = start && !busy;
	assign accept_last = accept && last;

	// Clamp the box to the store and limit the step count to width minus one.
	always_comb begin
		logic [31:0] wm1;
		w_new = (32'(box_width_q) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(box_width_q);
		h_new = (32'(box_height_q) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(box_height_q);
		wm1   = 32'(w_new) - 32'd1;
		steps_new = (32'(max_step_q) < wm1) ? CW'(max_step_q) : CW'(wm1);
	end

	// Counter wrap conditions for the step, row and column loops.
	assign s_wrap = (s_q == steps_q);
	assign r_wrap = (HW'(r_q) + HW'(1) == h_q);
	assign c_wrap = (WW'(c_q) + WW'(1) == w_q);

	// Mirror addresses; a side that falls outside the box reads as zero later.
	assign va       = (s_q <= c_q);
	assign vb       = (XW'(c_q) + XW'(s_q) < XW'(w_q));
	assign addr_a_x = (AW+1)'(row_base_q) + (AW+1)'(c_q) - (AW+1)'(s_q);
	assign addr_b_x = (AW+1)'(row_base_q) + (AW+1)'(c_q) + (AW+1)'(s_q);
	assign addr_a   = addr_a_x[AW-1:0];
	assign addr_b   = addr_b_x[AW-1:0];

	// Next state and busy.
	always_comb begin
		state_d = state_q;
		busy    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (accept_last && w_new != '0 && h_new != '0 && steps_new != '0)
					state_d = ST_RUN;
			end
			ST_RUN: begin
				if (s_wrap && r_wrap && c_wrap)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_left_q   <= '0;
			box_width_q  <= '0;
			box_height_q <= '0;
			max_step_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BOX_LEFT:   box_left_q   <= cfg_data[LEFT_W-1:0];
				CFG_BOX_WIDTH:  box_width_q  <= cfg_data[BW_W-1:0];
				CFG_BOX_HEIGHT: box_height_q <= cfg_data[BH_W-1:0];
				CFG_MAX_STEP:   max_step_q   <= cfg_data[STEP_W-1:0];
				default:        box_left_q   <= box_left_q;
			endcase
		end
	end

	// Pixel memory: one write port for loading, two registered read ports for the search.
	always_ff @(posedge clk) begin
		if (accept)
			mem[load_idx_q] <= pixel;
		rd_a_s1 <= mem[addr_a];
		rd_b_s1 <= mem[addr_b];
	end

	// Load index wraps at the end of the store and returns to zero after the last pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			load_idx_q <= '0;
		else if (accept) begin
			if (last || 32'(load_idx_q) == DEPTH - 1)
				load_idx_q <= '0;
			else
				load_idx_q <= load_idx_q + AW'(1);
		end
	end

	// Issue counters walk steps, then rows, then columns, one term per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q        <= '0;
			r_q        <= '0;
			s_q        <= '0;
			row_base_q <= '0;
			w_q        <= '0;
			h_q        <= '0;
			steps_q    <= '0;
		end else if (state_q == ST_IDLE) begin
			c_q        <= '0;
			r_q        <= '0;
			s_q        <= CW'(1);
			row_base_q <= '0;
			if (accept_last) begin
				w_q     <= w_new;
				h_q     <= h_new;
				steps_q <= steps_new;
			end
		end else if (state_q == ST_RUN) begin
			if (!s_wrap)
				s_q <= s_q + CW'(1);
			else begin
				s_q <= CW'(1);
				if (!r_wrap) begin
					r_q        <= r_q + RW'(1);
					row_base_q <= row_base_q + AW'(w_q);
				end else begin
					r_q        <= '0;
					row_base_q <= '0;
					c_q        <= c_q + CW'(1);
				end
			end
		end
	end

	// Side information travels with the memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_s1     <= 1'b0;
			va_s1       <= 1'b0;
			vb_s1       <= 1'b0;
			col_end_s1  <= 1'b0;
			last_col_s1 <= 1'b0;
			col_s1      <= '0;
		end else begin
			term_s1     <= (state_q == ST_RUN);
			va_s1       <= va;
			vb_s1       <= vb;
			col_end_s1  <= (state_q == ST_RUN) && s_wrap && r_wrap;
			last_col_s1 <= c_wrap;
			col_s1      <= c_q;
		end
	end

	// Shared absolute difference and saturating accumulate.
	assign pa      = va_s1 ? rd_a_s1 : '0;
	assign pb      = vb_s1 ? rd_b_s1 : '0;
	assign diff    = !term_s1 ? '0 : ((pa > pb) ? pa - pb : pb - pa);
	assign acc_x   = {1'b0, sum_q} + (COST_W+1)'(diff);
	assign acc_sat = acc_x[COST_W] ? COST_MAX : acc_x[COST_W-1:0];

	// The first column always wins; later ones only when strictly cheaper.
	assign better       = (col_s1 == '0) || (acc_sat < best_q);
	assign best_new     = better ? acc_sat : best_q;
	assign best_col_new = better ? col_s1 : best_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			best_q     <= '0;
			best_col_q <= '0;
		end else if (term_s1) begin
			if (col_end_s1) begin
				sum_q      <= '0;
				best_q     <= best_new;
				best_col_q <= best_col_new;
			end else
				sum_q <= acc_sat;
		end
	end

	// Result register: the search end, or an empty or degenerate box without a search.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			found_q <= 1'b0;
			axis_q  <= '0;
			cost_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (term_s1 && col_end_s1 && last_col_s1) begin
				done_q  <= 1'b1;
				found_q <= 1'b1;
				axis_q  <= AXIS_W'(box_left_q) + AXIS_W'(best_col_new);
				cost_q  <= best_new;
			end else if (accept_last && state_d == ST_IDLE) begin
				done_q  <= 1'b1;
				found_q <= (w_new != '0);
				axis_q  <= (w_new != '0) ? AXIS_W'(box_left_q) : '0;
				cost_q  <= '0;
			end
		end
	end

	assign done   = done_q;
	assign found  = found_q;
	assign axis_x = axis_q;
	assign cost   = cost_q;

endmodule

@@ hw/rtl/sas_checker.sv @@
// Port-level checks for the symmetry axis search block, bound to its top level.
// Depends on sas_pkg for field widths.
module sas_checker
	import sas_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              last,
	input logic              done,
	input logic              found,
	input logic [AXIS_W-1:0] axis_x,
	input logic [COST_W-1:0] cost
);

	// A search only begins after a request that carries the last pixel.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && last))
		else $error("busy rose without a last-pixel request");

	// The end of a search always shows its result.
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("search ended without a result strobe");

	// An empty box reports zero axis and cost.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (axis_x == '0 && cost == '0))
		else $error("empty box result carries nonzero fields");

	// A result follows a search or a last-pixel request.
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start && last)))
		else $error("result strobe without a cause");

endmodule

bind symmetry_axis_search sas_checker u_sas_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.last   (last),
	.done   (done),
	.found  (found),
	.axis_x (axis_x),
	.cost   (cost)
);
